// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bpc_pkg.sv =====
// Types and constants of the barometric compensation block.
`default_nettype none

package bpc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int PRESS_W   = 20;
    localparam int TEMP_W    = 19;
    localparam int CFG_IDX_W = 3;

    // Register stages of the datapath, the output register included.
    localparam int STAGES = 9;
    localparam int CNT_W  = $clog2(STAGES + 1);

    localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [19:0] TEMP_LOW  = -20'sd1500;
    localparam logic signed [19:0] TEMP_MIN  = -20'sd262144;
    localparam logic signed [19:0] TEMP_MAX  = 20'sd262143;

    localparam logic signed [45:0] K_OFF_D   = 46'sd61;
    localparam logic signed [45:0] K_OFF_E   = 46'sd15;
    localparam logic signed [45:0] K_SENS_D  = 46'sd2;
    localparam logic signed [45:0] K_SENS_E  = 46'sd8;

    localparam logic signed [31:0] PRESS_MAX_S = 32'sd1048575;
    localparam logic [PRESS_W-1:0] PRESS_MAX   = 20'hFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } coef_t;

endpackage

`default_nettype wire

// ===== src/bpc_if.sv =====
// Handshake interfaces: sample input, result output, configuration writes.
`default_nettype none

interface bpc_in_if;
    logic                        valid;
    logic                        ready;
    logic [bpc_pkg::RAW_W-1:0]   raw_pressure;
    logic [bpc_pkg::RAW_W-1:0]   raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if;
    logic                              valid;
    logic                              ready;
    logic [bpc_pkg::PRESS_W-1:0]       pressure_pa;
    logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi;

    modport source (output valid, output pressure_pa, output temperature_centi, input ready);
    modport sink   (input valid, input pressure_pa, input temperature_centi, output ready);
endinterface

interface bpc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bpc_pkg::CFG_IDX_W-1:0] index;
    logic [bpc_pkg::COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/bpc_coef_regs.sv =====
// Calibration coefficient register file.
`default_nettype none

module bpc_coef_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bpc_cfg_if.sink            cfg,
    output bpc_pkg::coef_t     coef
);
    import bpc_pkg::*;

    coef_t coef_reg;
    coef_t coef_next;

    assign cfg.ready = 1'b1;
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_C1:  coef_next.c1 = cfg.data;
                REG_C2:  coef_next.c2 = cfg.data;
                REG_C3:  coef_next.c3 = cfg.data;
                REG_C4:  coef_next.c4 = cfg.data;
                REG_C5:  coef_next.c5 = cfg.data;
                REG_C6:  coef_next.c6 = cfg.data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/baro_pressure_temp_compensation.sv =====
// Top level: second-order barometric pressure and temperature compensation pipeline.
//
//   channel   dir   payload                               handshake
//   sample    in    raw_pressure, raw_temperature         valid / ready
//   result    out   pressure_pa, temperature_centi        valid / ready
//   cfg       in    index (c1..c6 = 0..5), data           valid / ready (always ready)
//
// Nine register stages; one request per cycle while result ready is high.
// The rate is set by the pipeline: multipliers for dT products, the squares, and
// the 24 x 40 pressure product split into two partial products over two stages.
// Each stage advances when it is empty or the stage after it advances, so bubbles fill
// while the output stalls; nothing is dropped or repeated.
// Reset clears valid bits and coefficients; coefficients reset to zero.
`default_nettype none

module baro_pressure_temp_compensation (
    input  wire logic clk,
    input  wire logic rst_n,
    bpc_in_if.sink    sample,
    bpc_out_if.source result,
    bpc_cfg_if.sink   cfg
);
    import bpc_pkg::*;

    coef_t coef;

    bpc_coef_regs u_coef_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef)
    );

    logic [STAGES:1] vld_reg;
    logic [STAGES:1] vld_next;
    logic [STAGES:1] adv;

    // stage 1
    logic [RAW_W-1:0]    d1_s1_reg;
    logic signed [24:0]  dt_s1_reg,   dt_s1_next;
    // stage 2
    logic [RAW_W-1:0]    d1_s2_reg;
    logic signed [41:0]  pof_s2_reg,  pof_s2_next;
    logic signed [41:0]  psn_s2_reg,  psn_s2_next;
    logic signed [41:0]  ptm_s2_reg,  ptm_s2_next;
    logic signed [49:0]  pdd_s2_reg,  pdd_s2_next;
    // stage 3
    logic [RAW_W-1:0]    d1_s3_reg;
    logic signed [35:0]  off_s3_reg,  off_s3_next;
    logic signed [35:0]  sens_s3_reg, sens_s3_next;
    logic signed [19:0]  temp_s3_reg, temp_s3_next;
    logic [17:0]         ddc_s3_reg,  ddc_s3_next;
    // stage 4
    logic [RAW_W-1:0]    d1_s4_reg;
    logic signed [35:0]  off_s4_reg;
    logic signed [35:0]  sens_s4_reg;
    logic signed [19:0]  temp_s4_reg, temp_s4_next;
    logic signed [39:0]  dsq_s4_reg,  dsq_s4_next;
    logic signed [39:0]  esq_s4_reg,  esq_s4_next;
    logic                low_s4_reg,  low_s4_next;
    logic                vlow_s4_reg, vlow_s4_next;
    logic signed [19:0]  t_dev, u_dev;
    // stage 5
    logic [RAW_W-1:0]    d1_s5_reg;
    logic signed [35:0]  off_s5_reg;
    logic signed [35:0]  sens_s5_reg;
    logic signed [41:0]  ocorr_s5_reg, ocorr_s5_next;
    logic signed [39:0]  scorr_s5_reg, scorr_s5_next;
    logic signed [TEMP_W-1:0] tout_s5_reg, tout_s5_next;
    logic signed [45:0]  d61, e15, d2x, e8x;
    // stage 6
    logic [RAW_W-1:0]    d1_s6_reg;
    logic signed [41:0]  off_s6_reg,  off_s6_next;
    logic signed [39:0]  sens_s6_reg, sens_s6_next;
    logic signed [TEMP_W-1:0] tout_s6_reg;
    // stage 7
    logic signed [41:0]  off_s7_reg;
    logic [43:0]         plo_s7_reg,  plo_s7_next;
    logic signed [44:0]  phi_s7_reg,  phi_s7_next;
    logic signed [TEMP_W-1:0] tout_s7_reg;
    // stage 8
    logic signed [41:0]  off_s8_reg;
    logic signed [44:0]  q_s8_reg,    q_s8_next;
    logic signed [65:0]  prod_sum;
    logic signed [TEMP_W-1:0] tout_s8_reg;
    // stage 9 (output)
    logic [PRESS_W-1:0]  press_s9_reg, press_s9_next;
    logic signed [TEMP_W-1:0] tout_s9_reg;
    logic signed [46:0]  p_diff;
    logic signed [31:0]  p_full;

    always_comb
    begin
        adv[STAGES] = !vld_reg[STAGES] || result.ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = vld_reg;
        if (adv[1])
        begin
            vld_next[1] = sample.valid;
        end
        for (int k = 2; k <= STAGES; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    assign sample.ready             = adv[1];
    assign result.valid             = vld_reg[STAGES];
    assign result.pressure_pa       = press_s9_reg;
    assign result.temperature_centi = tout_s9_reg;

    // datapath
    always_comb
    begin
        // dT
        dt_s1_next = 25'($signed({2'b00, sample.raw_temperature})
                         - $signed({2'b00, coef.c5, 8'h00}));

        // products with dT
        pof_s2_next = $signed({1'b0, coef.c4}) * dt_s1_reg;
        psn_s2_next = $signed({1'b0, coef.c3}) * dt_s1_reg;
        ptm_s2_next = $signed({1'b0, coef.c6}) * dt_s1_reg;
        pdd_s2_next = dt_s1_reg * dt_s1_reg;

        // OFF, SENS, TEMP
        off_s3_next  = $signed({3'b000, coef.c2, 17'h0}) + 36'(pof_s2_reg >>> 6);
        sens_s3_next = $signed({4'h0, coef.c1, 16'h0}) + 36'(psn_s2_reg >>> 7);
        temp_s3_next = TEMP_REF + 20'(ptm_s2_reg >>> 23);
        ddc_s3_next  = 18'(pdd_s2_reg >>> 31);

        // squares for the low-temperature terms
        t_dev        = temp_s3_reg - TEMP_REF;
        u_dev        = temp_s3_reg - TEMP_LOW;
        dsq_s4_next  = t_dev * t_dev;
        esq_s4_next  = u_dev * u_dev;
        low_s4_next  = temp_s3_reg < TEMP_REF;
        vlow_s4_next = temp_s3_reg < TEMP_LOW;
        temp_s4_next = low_s4_next ? temp_s3_reg - $signed({2'b00, ddc_s3_reg})
                                   : temp_s3_reg;

        // correction sums
        d61 = 46'(dsq_s4_reg) * K_OFF_D;
        e15 = 46'(esq_s4_reg) * K_OFF_E;
        d2x = 46'(dsq_s4_reg) * K_SENS_D;
        e8x = 46'(esq_s4_reg) * K_SENS_E;
        ocorr_s5_next = (low_s4_reg  ? 42'(d61 >>> 4) : 42'sd0)
                      + (vlow_s4_reg ? 42'(e15)       : 42'sd0);
        scorr_s5_next = (low_s4_reg  ? 40'(d2x) : 40'sd0)
                      + (vlow_s4_reg ? 40'(e8x) : 40'sd0);
        if (temp_s4_reg < TEMP_MIN)
        begin
            tout_s5_next = TEMP_W'(TEMP_MIN);
        end
        else if (temp_s4_reg > TEMP_MAX)
        begin
            tout_s5_next = TEMP_W'(TEMP_MAX);
        end
        else
        begin
            tout_s5_next = TEMP_W'(temp_s4_reg);
        end

        // corrected OFF, SENS
        off_s6_next  = 42'(off_s5_reg) - ocorr_s5_reg;
        sens_s6_next = 40'(sens_s5_reg) - scorr_s5_reg;

        // D1 * SENS as two partial products
        plo_s7_next = 44'(d1_s6_reg) * 44'(sens_s6_reg[19:0]);
        phi_s7_next = $signed({1'b0, d1_s6_reg}) * $signed(sens_s6_reg[39:20]);

        prod_sum  = (66'(phi_s7_reg) <<< 20) + $signed({22'h0, plo_s7_reg});
        q_s8_next = 45'(prod_sum >>> 21);

        // pressure and clamp
        p_diff = 47'(q_s8_reg) - 47'(off_s8_reg);
        p_full = 32'(p_diff >>> 15);
        if (p_full < 32'sd0)
        begin
            press_s9_next = '0;
        end
        else if (p_full > PRESS_MAX_S)
        begin
            press_s9_next = PRESS_MAX;
        end
        else
        begin
            press_s9_next = p_full[PRESS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            d1_s1_reg <= sample.raw_pressure;
            dt_s1_reg <= dt_s1_next;
        end
        if (adv[2])
        begin
            d1_s2_reg  <= d1_s1_reg;
            pof_s2_reg <= pof_s2_next;
            psn_s2_reg <= psn_s2_next;
            ptm_s2_reg <= ptm_s2_next;
            pdd_s2_reg <= pdd_s2_next;
        end
        if (adv[3])
        begin
            d1_s3_reg   <= d1_s2_reg;
            off_s3_reg  <= off_s3_next;
            sens_s3_reg <= sens_s3_next;
            temp_s3_reg <= temp_s3_next;
            ddc_s3_reg  <= ddc_s3_next;
        end
        if (adv[4])
        begin
            d1_s4_reg   <= d1_s3_reg;
            off_s4_reg  <= off_s3_reg;
            sens_s4_reg <= sens_s3_reg;
            temp_s4_reg <= temp_s4_next;
            dsq_s4_reg  <= dsq_s4_next;
            esq_s4_reg  <= esq_s4_next;
            low_s4_reg  <= low_s4_next;
            vlow_s4_reg <= vlow_s4_next;
        end
        if (adv[5])
        begin
            d1_s5_reg    <= d1_s4_reg;
            off_s5_reg   <= off_s4_reg;
            sens_s5_reg  <= sens_s4_reg;
            ocorr_s5_reg <= ocorr_s5_next;
            scorr_s5_reg <= scorr_s5_next;
            tout_s5_reg  <= tout_s5_next;
        end
        if (adv[6])
        begin
            d1_s6_reg   <= d1_s5_reg;
            off_s6_reg  <= off_s6_next;
            sens_s6_reg <= sens_s6_next;
            tout_s6_reg <= tout_s5_reg;
        end
        if (adv[7])
        begin
            off_s7_reg  <= off_s6_reg;
            plo_s7_reg  <= plo_s7_next;
            phi_s7_reg  <= phi_s7_next;
            tout_s7_reg <= tout_s6_reg;
        end
        if (adv[8])
        begin
            off_s8_reg  <= off_s7_reg;
            q_s8_reg    <= q_s8_next;
            tout_s8_reg <= tout_s7_reg;
        end
        if (adv[9])
        begin
            press_s9_reg <= press_s9_next;
            tout_s9_reg  <= tout_s8_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpc_checker.sv =====
// Port-level checker for the compensation block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bpc_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic [bpc_pkg::PRESS_W-1:0]         pressure_pa,
    input wire logic signed [bpc_pkg::TEMP_W-1:0]   temperature_centi
);
    import bpc_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!in_acc && out_acc)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(pressure_pa) && $stable(temperature_centi), "result changed while stalled")
    `ASSERT_SAME(a_no_phantom, clk, rst_n, out_valid, count_reg != '0, "result without a request in flight")
    `ASSERT_SAME(a_depth, clk, rst_n, 1'b1, count_reg <= CNT_W'(STAGES), "more requests in flight than stages")
    `ASSERT_SAME(a_drain_ready, clk, rst_n, !out_valid, in_ready, "input stalled with empty output register")

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (sample.valid),
    .in_ready          (sample.ready),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .pressure_pa       (result.pressure_pa),
    .temperature_centi (result.temperature_centi)
);

`default_nettype wire
